[rtl/core/pfz_pkg.sv]
// ----------------------------------------------------------------------------
// Plane fit z interpolator package
// Shared codes and control types of the plane fit z interpolator.
// ----------------------------------------------------------------------------
package pfz_pkg;

  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  localparam logic [1:0] LAST_CORNER = 2'd3;

  typedef struct packed {
    logic start;
    logic keep;
    logic sub;
  } mac_cmd_t;

endpackage

[rtl/core/pfz_if.sv]
// ----------------------------------------------------------------------------
// Plane fit z interpolator channels
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface pfz_in_if #(
  parameter int CB = 18
);
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [1:0]           point_index;
  logic signed [CB-1:0] coord_x;
  logic signed [CB-1:0] coord_y;
  logic signed [CB-1:0] coord_z;
  logic [1:0]           plane_index;

  modport source (output valid, action, point_index, coord_x, coord_y, coord_z,
                  plane_index, input ready);
  modport sink (input valid, action, point_index, coord_x, coord_y, coord_z,
                plane_index, output ready);
endinterface

interface pfz_out_if #(
  parameter int CB = 18
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] z_level;
  logic                 z_valid;
  logic                 z_saturated;
  logic                 fit_done;
  logic signed [CB-1:0] max_level;
  logic signed [CB-1:0] min_level;
  logic signed [CB-1:0] avg_level;

  modport source (output valid, z_level, z_valid, z_saturated, fit_done, max_level,
                  min_level, avg_level, input ready);
  modport sink (input valid, z_level, z_valid, z_saturated, fit_done, max_level,
                min_level, avg_level, output ready);
endinterface

[rtl/core/pfz_mac.sv]
// ----------------------------------------------------------------------------
// Bit-serial multiply-accumulate
// Adds or subtracts a*b into the accumulator, one bit of b per cycle.
// ----------------------------------------------------------------------------
module pfz_mac
  import pfz_pkg::*;
#(
  parameter int CB = 18
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_cmd_t                 cmd,
  input  logic signed [2*CB+2:0]   a,
  input  logic signed [CB:0]       b,
  input  logic signed [3*CB+5:0]   init,
  output logic signed [3*CB+5:0]   acc,
  output logic                     done
);

  localparam int DW = CB + 1;
  localparam int NW = 2 * CB + 3;
  localparam int AW = 3 * CB + 6;
  localparam int CW = $clog2(DW);

  logic [AW-1:0] a_r, a_nxt;
  logic [DW-1:0] b_r, b_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          sub_r, sub_nxt;
  logic          last;

  assign last = (cnt_r == CW'(DW - 1));

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sub_nxt  = sub_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      a_nxt    = {{(AW-NW){a[NW-1]}}, a};
      b_nxt    = b;
      acc_nxt  = cmd.keep ? acc_r : init;
      cnt_nxt  = '0;
      sub_nxt  = cmd.sub;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = (sub_r ^ last) ? acc_r - a_r : acc_r + a_r;
      end
      a_nxt   = {a_r[AW-2:0], 1'b0};
      b_nxt   = {1'b0, b_r[DW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    sub_r <= sub_nxt;
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

[rtl/core/pfz_div.sv]
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pfz_div #(
  parameter int CB = 18
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [3*CB+5:0] num,
  input  logic signed [2*CB+2:0] den,
  output logic [3*CB+5:0]        quo_mag,
  output logic                   quo_neg,
  output logic                   done
);

  localparam int NW = 2 * CB + 3;
  localparam int AW = 3 * CB + 6;
  localparam int CW = $clog2(AW);

  logic [AW-1:0] q_r, q_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW:0]   shifted;
  logic [NW+1:0] trial;

  assign shifted = {rem_r, q_r[AW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, d_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = num[AW-1] ? AW'(-num) : AW'(num);
      d_nxt    = den[NW-1] ? NW'(-den) : NW'(den);
      rem_nxt  = '0;
      cnt_nxt  = '0;
      neg_nxt  = num[AW-1] ^ den[NW-1];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = trial[NW+1] ? shifted[NW-1:0] : trial[NW-1:0];
      q_nxt   = {q_r[AW-2:0], ~trial[NW+1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(AW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign quo_mag = q_r;
  assign quo_neg = neg_r;
  assign done    = done_r;

endmodule

[rtl/core/plane_fit_z_interpolator.sv]
// ----------------------------------------------------------------------------
// Plane fit z interpolator
// Fits three planes through four corner points and interpolates z on them.
// ----------------------------------------------------------------------------
// Every input transaction on in_ch yields exactly one result transaction on
// out_ch. A load of corners 0 to 2 only stores the point. A load of corner 3
// runs the fit: 27 serial multiply-accumulate passes, nine for each plane.
// A query runs two multiply-accumulate passes and then a radix-2 divider; a
// query on a plane with a zero normal z answers without them, and the
// multiplier and divider are bit-serial. One transaction is worked on at a
// time. The result sits in an output register: in_ch is ready again once the
// result has moved into it, which waits while an earlier result is unread,
// so a stalled receiver holds back both the next result and in_ch. Reset
// clears normals, offsets and levels; corners hold no value until loaded.
// ----------------------------------------------------------------------------
module plane_fit_z_interpolator
  import pfz_pkg::*;
#(
  parameter int COORD_BITS = 18,
  parameter int NUM_PLANES = 3
) (
  input  logic clk,
  input  logic rst_n,
  pfz_in_if.sink    in_ch,
  pfz_out_if.source out_ch
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int NW = 2 * CB + 3;
  localparam int AW = 3 * CB + 6;
  localparam int PW = $clog2(NUM_PLANES);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MAC_GO   = 3'd1;
  localparam logic [2:0] ST_MAC_WAIT = 3'd2;
  localparam logic [2:0] ST_DIV_GO   = 3'd3;
  localparam logic [2:0] ST_DIV_WAIT = 3'd4;
  localparam logic [2:0] ST_EMIT     = 3'd5;

  localparam logic [3:0] K_NX_A  = 4'd0;
  localparam logic [3:0] K_NX_B  = 4'd1;
  localparam logic [3:0] K_NY_A  = 4'd2;
  localparam logic [3:0] K_NY_B  = 4'd3;
  localparam logic [3:0] K_NZ_A  = 4'd4;
  localparam logic [3:0] K_NZ_B  = 4'd5;
  localparam logic [3:0] K_OFF_X = 4'd6;
  localparam logic [3:0] K_OFF_Y = 4'd7;
  localparam logic [3:0] K_OFF_Z = 4'd8;

  logic [2:0]           state_r, state_nxt;
  logic                 query_r, query_nxt;
  logic [3:0]           k_r, k_nxt;
  logic [PW-1:0]        plane_r, plane_nxt;
  logic [PW-1:0]        qplane_r, qplane_nxt;

  logic signed [CB-1:0] px_r [4];
  logic signed [CB-1:0] py_r [4];
  logic signed [CB-1:0] pz_r [4];
  logic signed [CB-1:0] qx_r, qy_r;

  logic signed [NW-1:0] nx_r  [NUM_PLANES];
  logic signed [NW-1:0] ny_r  [NUM_PLANES];
  logic signed [NW-1:0] nz_r  [NUM_PLANES];
  logic signed [AW-1:0] off_r [NUM_PLANES];

  logic signed [CB-1:0] lmax_r, lmin_r, lavg_r;
  logic signed [CB-1:0] res_z_r, res_z_nxt;
  logic                 res_valid_r, res_valid_nxt;
  logic                 res_sat_r, res_sat_nxt;
  logic                 res_done_r, res_done_nxt;

  logic                 out_valid_r;
  logic signed [CB-1:0] out_z_r, out_max_r, out_min_r, out_avg_r;
  logic                 out_zv_r, out_sat_r, out_done_r;

  logic                 accept;
  logic                 emit;
  logic [PW-1:0]        idx;
  logic [PW-1:0]        in_plane;
  logic                 in_plane_ok;

  mac_cmd_t             mcmd;
  logic signed [NW-1:0] ma;
  logic signed [DW-1:0] mb;
  logic signed [AW-1:0] minit;
  logic signed [AW-1:0] macc;
  logic                 mdone;
  logic                 dstart;
  logic [AW-1:0]        dmag;
  logic                 dneg;
  logic                 ddone;

  logic signed [CB-1:0] bx, by, bz, e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [DW-1:0] ax, ay, az, cx, cy, cz;

  logic signed [CB-1:0] z3;
  logic signed [CB-1:0] mx01, mx23, mn01, mn23, fmax, fmin;
  logic signed [CB+1:0] zsum, zsum_adj;

  logic [AW-1:0]        hi_w, lo_mag_w;
  logic signed [CB-1:0] z_q;
  logic                 z_sat;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign emit         = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign idx          = query_r ? qplane_r : plane_r;
  assign in_plane     = in_ch.plane_index[PW-1:0];
  assign in_plane_ok  = ({1'b0, in_ch.plane_index} < 3'(NUM_PLANES));

  always_comb begin
    bx = px_r[0]; by = py_r[0]; bz = pz_r[0];
    e1x = px_r[1]; e1y = py_r[1]; e1z = pz_r[1];
    e2x = px_r[2]; e2y = py_r[2]; e2z = pz_r[2];
    case (plane_r)
      PW'(1): begin
        bx = px_r[1]; by = py_r[1]; bz = pz_r[1];
        e1x = px_r[0]; e1y = py_r[0]; e1z = pz_r[0];
        e2x = px_r[3]; e2y = py_r[3]; e2z = pz_r[3];
      end
      PW'(2): begin
        bx = px_r[2]; by = py_r[2]; bz = pz_r[2];
        e1x = px_r[0]; e1y = py_r[0]; e1z = pz_r[0];
        e2x = px_r[3]; e2y = py_r[3]; e2z = pz_r[3];
      end
      default: begin
      end
    endcase
  end

  assign ax = DW'(bx) - DW'(e1x);
  assign ay = DW'(by) - DW'(e1y);
  assign az = DW'(bz) - DW'(e1z);
  assign cx = DW'(bx) - DW'(e2x);
  assign cy = DW'(by) - DW'(e2y);
  assign cz = DW'(bz) - DW'(e2z);

  always_comb begin
    ma = NW'(ay);
    mb = cz;
    mcmd.start = (state_r == ST_MAC_GO);
    mcmd.keep  = 1'b0;
    mcmd.sub   = 1'b0;
    if (query_r) begin
      mcmd.sub = 1'b1;
      if (k_r == K_NX_A) begin
        ma = nx_r[idx];
        mb = DW'(qx_r);
      end else begin
        ma = ny_r[idx];
        mb = DW'(qy_r);
        mcmd.keep = 1'b1;
      end
    end else begin
      case (k_r)
        K_NX_A: begin ma = NW'(ay); mb = cz; end
        K_NX_B: begin ma = NW'(az); mb = cy; mcmd.keep = 1'b1; mcmd.sub = 1'b1; end
        K_NY_A: begin ma = NW'(az); mb = cx; end
        K_NY_B: begin ma = NW'(ax); mb = cz; mcmd.keep = 1'b1; mcmd.sub = 1'b1; end
        K_NZ_A: begin ma = NW'(ax); mb = cy; end
        K_NZ_B: begin ma = NW'(ay); mb = cx; mcmd.keep = 1'b1; mcmd.sub = 1'b1; end
        K_OFF_X: begin ma = nx_r[idx]; mb = DW'(bx); end
        K_OFF_Y: begin ma = ny_r[idx]; mb = DW'(by); mcmd.keep = 1'b1; end
        K_OFF_Z: begin ma = nz_r[idx]; mb = DW'(bz); mcmd.keep = 1'b1; end
        default: begin end
      endcase
    end
  end

  assign minit = query_r ? off_r[idx] : '0;

  pfz_mac #(.CB(CB)) u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (mcmd),
    .a    (ma),
    .b    (mb),
    .init (minit),
    .acc  (macc),
    .done (mdone)
  );

  assign dstart = (state_r == ST_DIV_GO);

  pfz_div #(.CB(CB)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dstart),
    .num    (macc),
    .den    (nz_r[idx]),
    .quo_mag(dmag),
    .quo_neg(dneg),
    .done   (ddone)
  );

  assign hi_w     = AW'((64'd1 << (CB - 1)) - 64'd1);
  assign lo_mag_w = AW'(64'd1 << (CB - 1));

  always_comb begin
    z_sat = 1'b0;
    z_q   = CB'(dmag);
    if (!dneg) begin
      if (dmag > hi_w) begin
        z_sat = 1'b1;
        z_q   = CB'(hi_w);
      end
    end else begin
      z_q = CB'(-dmag);
      if (dmag > lo_mag_w) begin
        z_sat = 1'b1;
        z_q   = {1'b1, {(CB-1){1'b0}}};
      end
    end
  end

  assign z3   = in_ch.coord_z;
  assign mx01 = (pz_r[1] > pz_r[0]) ? pz_r[1] : pz_r[0];
  assign mx23 = (z3 > pz_r[2]) ? z3 : pz_r[2];
  assign mn01 = (pz_r[1] < pz_r[0]) ? pz_r[1] : pz_r[0];
  assign mn23 = (z3 < pz_r[2]) ? z3 : pz_r[2];
  assign fmax = (mx23 > mx01) ? mx23 : mx01;
  assign fmin = (mn23 < mn01) ? mn23 : mn01;
  assign zsum = (CB+2)'(pz_r[0]) + (CB+2)'(pz_r[1]) + (CB+2)'(pz_r[2]) + (CB+2)'(z3);
  assign zsum_adj = zsum + (zsum[CB+1] ? (CB+2)'(3) : (CB+2)'(0));

  always_comb begin
    state_nxt     = state_r;
    query_nxt     = query_r;
    k_nxt         = k_r;
    plane_nxt     = plane_r;
    qplane_nxt    = qplane_r;
    res_z_nxt     = res_z_r;
    res_valid_nxt = res_valid_r;
    res_sat_nxt   = res_sat_r;
    res_done_nxt  = res_done_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_z_nxt     = '0;
          res_valid_nxt = 1'b0;
          res_sat_nxt   = 1'b0;
          res_done_nxt  = 1'b0;
          k_nxt         = K_NX_A;
          plane_nxt     = '0;
          qplane_nxt    = in_plane;
          state_nxt     = ST_EMIT;
          if (in_ch.action == ACTION_LOAD) begin
            query_nxt = 1'b0;
            if (in_ch.point_index == LAST_CORNER) begin
              res_done_nxt = 1'b1;
              state_nxt    = ST_MAC_GO;
            end
          end else begin
            query_nxt = 1'b1;
            if (in_plane_ok && (nz_r[in_plane] != '0)) begin
              state_nxt = ST_MAC_GO;
            end
          end
        end
      end
      ST_MAC_GO: begin
        state_nxt = ST_MAC_WAIT;
      end
      ST_MAC_WAIT: begin
        if (mdone) begin
          if (query_r) begin
            if (k_r == K_NX_A) begin
              k_nxt     = K_NX_B;
              state_nxt = ST_MAC_GO;
            end else begin
              state_nxt = ST_DIV_GO;
            end
          end else if (k_r == K_OFF_Z) begin
            k_nxt = K_NX_A;
            if (plane_r == PW'(NUM_PLANES - 1)) begin
              state_nxt = ST_EMIT;
            end else begin
              plane_nxt = plane_r + 1'b1;
              state_nxt = ST_MAC_GO;
            end
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_MAC_GO;
          end
        end
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (ddone) begin
          res_z_nxt     = z_q;
          res_valid_nxt = 1'b1;
          res_sat_nxt   = z_sat;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      query_r     <= 1'b0;
      k_r         <= K_NX_A;
      plane_r     <= '0;
      out_valid_r <= 1'b0;
      lmax_r      <= '0;
      lmin_r      <= '0;
      lavg_r      <= '0;
      for (int i = 0; i < NUM_PLANES; i++) begin
        nx_r[i]  <= '0;
        ny_r[i]  <= '0;
        nz_r[i]  <= '0;
        off_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      query_r <= query_nxt;
      k_r     <= k_nxt;
      plane_r <= plane_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept && (in_ch.action == ACTION_LOAD) && (in_ch.point_index == LAST_CORNER)) begin
        lmax_r <= fmax;
        lmin_r <= fmin;
        lavg_r <= zsum_adj[CB+1:2];
      end
      if ((state_r == ST_MAC_WAIT) && mdone && !query_r) begin
        case (k_r)
          K_NX_B:  nx_r[plane_r]  <= NW'(macc);
          K_NY_B:  ny_r[plane_r]  <= NW'(macc);
          K_NZ_B:  nz_r[plane_r]  <= NW'(macc);
          K_OFF_Z: off_r[plane_r] <= macc;
          default: begin end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    qplane_r    <= qplane_nxt;
    res_z_r     <= res_z_nxt;
    res_valid_r <= res_valid_nxt;
    res_sat_r   <= res_sat_nxt;
    res_done_r  <= res_done_nxt;
    if (accept) begin
      qx_r <= in_ch.coord_x;
      qy_r <= in_ch.coord_y;
      if (in_ch.action == ACTION_LOAD) begin
        px_r[in_ch.point_index] <= in_ch.coord_x;
        py_r[in_ch.point_index] <= in_ch.coord_y;
        pz_r[in_ch.point_index] <= in_ch.coord_z;
      end
    end
    if (emit) begin
      out_z_r    <= res_z_r;
      out_zv_r   <= res_valid_r;
      out_sat_r  <= res_sat_r;
      out_done_r <= res_done_r;
      out_max_r  <= lmax_r;
      out_min_r  <= lmin_r;
      out_avg_r  <= lavg_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.z_level     = out_z_r;
  assign out_ch.z_valid     = out_zv_r;
  assign out_ch.z_saturated = out_sat_r;
  assign out_ch.fit_done    = out_done_r;
  assign out_ch.max_level   = out_max_r;
  assign out_ch.min_level   = out_min_r;
  assign out_ch.avg_level   = out_avg_r;

endmodule
